### hw/rtl/fbscr_pkg.sv
// ----------------------------------------------------------------------------
// FSK bit slicer package
// Shared widths, register and control codes, and the sequencer program.
// ----------------------------------------------------------------------------
package fbscr_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W   = 16;
    localparam int BASE_W     = 15;
    localparam int GAIN_W     = 16;
    localparam int COEF_W     = 26;
    localparam int HIST_W     = 26;
    localparam int SUM_W      = 28;
    localparam int MUL_A_W    = 28;
    localparam int MUL_B_W    = 32;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 56;
    localparam int Q_SHIFT    = 22;
    localparam int PHASE_W    = 16;
    localparam int ERR_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 26;

    // Decision history spans the edge detector window plus the current bit.
    localparam int EDGE_SPAN  = 5;
    localparam int DHIST_W    = EDGE_SPAN + 1;

    // Phase landmarks and the scaling shift of the loop correction.
    localparam logic [PHASE_W:0] HALF_TURN = 17'h08000;
    localparam logic [PHASE_W:0] FULL_TURN = 17'h10000;
    localparam int LOOP_SHIFT = 31;

    // Reset values of the configuration registers.
    localparam logic [BASE_W-1:0] BASE_RESET = 15'd1521;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd164;

    // Slicer drive levels, +1 and -1 in Q3.22.
    localparam logic signed [HIST_W-1:0] DRIVE_POS = 26'sd4194304;
    localparam logic signed [HIST_W-1:0] DRIVE_NEG = -26'sd4194304;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PHASE_STEP_BASE = 4'd0,
        REG_LOOP_GAIN       = 4'd1,
        REG_S1_INPUT_COEF   = 4'd2,
        REG_S1_FB1_COEF     = 4'd3,
        REG_S1_FB2_COEF     = 4'd4,
        REG_S2_INPUT_COEF   = 4'd5,
        REG_S2_FB1_COEF     = 4'd6,
        REG_S2_FB2_COEF     = 4'd7
    } cfg_reg_t;

    // Multiplier operand selection.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SUM,
        MUL_FB1,
        MUL_FB2,
        MUL_GAIN,
        MUL_ERR
    } mul_sel_t;

    // Accumulator operation.
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    // Per-step action outside the multiply-accumulate path.
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_ACCEPT,
        ACT_FIN1,
        ACT_FIN2,
        ACT_PHASE
    } act_t;

    // Condition that must hold for the step to advance.
    typedef enum logic [1:0] {
        COND_NONE,
        COND_IN_VALID,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        logic     stage2;
        act_t     act;
        cond_t    cond;
        logic     last;
    } ctrl_word_t;

    localparam int STEP_W    = 4;

    // Program store: one control word per step.
    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '{MUL_NONE, ACC_NONE, 1'b0, ACT_NONE, COND_NONE, 1'b0};
        unique case (step)
            4'd0:  cw = '{MUL_NONE, ACC_NONE, 1'b0, ACT_ACCEPT, COND_IN_VALID, 1'b0};
            4'd1:  cw = '{MUL_SUM,  ACC_NONE, 1'b0, ACT_NONE,   COND_NONE,     1'b0};
            4'd2:  cw = '{MUL_FB1,  ACC_LOAD, 1'b0, ACT_NONE,   COND_NONE,     1'b0};
            4'd3:  cw = '{MUL_FB2,  ACC_ADD,  1'b0, ACT_NONE,   COND_NONE,     1'b0};
            4'd4:  cw = '{MUL_NONE, ACC_ADD,  1'b0, ACT_NONE,   COND_NONE,     1'b0};
            4'd5:  cw = '{MUL_NONE, ACC_NONE, 1'b0, ACT_FIN1,   COND_NONE,     1'b0};
            4'd6:  cw = '{MUL_SUM,  ACC_NONE, 1'b1, ACT_NONE,   COND_NONE,     1'b0};
            4'd7:  cw = '{MUL_FB1,  ACC_LOAD, 1'b1, ACT_NONE,   COND_NONE,     1'b0};
            4'd8:  cw = '{MUL_FB2,  ACC_ADD,  1'b1, ACT_NONE,   COND_NONE,     1'b0};
            4'd9:  cw = '{MUL_NONE, ACC_ADD,  1'b1, ACT_NONE,   COND_NONE,     1'b0};
            4'd10: cw = '{MUL_NONE, ACC_NONE, 1'b1, ACT_FIN2,   COND_NONE,     1'b0};
            4'd11: cw = '{MUL_GAIN, ACC_NONE, 1'b0, ACT_NONE,   COND_NONE,     1'b0};
            4'd12: cw = '{MUL_ERR,  ACC_NONE, 1'b0, ACT_NONE,   COND_NONE,     1'b0};
            4'd13: cw = '{MUL_NONE, ACC_NONE, 1'b0, ACT_PHASE,  COND_OUT_FREE, 1'b1};
            default: cw = '{MUL_NONE, ACC_NONE, 1'b0, ACT_NONE, COND_NONE,     1'b1};
        endcase
        return cw;
    endfunction

endpackage

### hw/rtl/fsk_bit_slicer_clock_recovery_core.sv
// ----------------------------------------------------------------------------
// FSK bit slicer with bit clock recovery
// Slices audio samples, low-pass filters the decision through two biquads,
// and recovers the bit clock with a phase accumulator steered by edges.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction  Content
//  input     s_valid, s_ready, s_sample[15:0]          in         audio sample
//  result    m_valid, m_ready, m_data_bit              out        recovered bit
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in         register write
//
// Each sample runs the whole program before the next transfer is taken:
// one program step per cycle unless a waiting bit holds the phase step, with all eight
// products going through one shared multiplier; s_ready returns at the first step.
// The result register is separate, so a waiting bit blocks only the final
// phase step, and only when that step has a new bit to deliver.
// Reset is synchronous and active low; it clears the step, filter, decision and phase state and restores registers.
// Configuration writes are taken in every cycle.
// ----------------------------------------------------------------------------
module fsk_bit_slicer_clock_recovery_core (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [fbscr_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic                                    m_data_bit,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [fbscr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [fbscr_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int Q_SHIFT_L = fbscr_pkg::Q_SHIFT;

    // Configuration registers.
    logic [fbscr_pkg::BASE_W-1:0]        base_reg;
    logic [fbscr_pkg::GAIN_W-1:0]        gain_reg;
    logic signed [fbscr_pkg::COEF_W-1:0] s1_coef_reg [3];
    logic signed [fbscr_pkg::COEF_W-1:0] s2_coef_reg [3];

    // Sequencer and datapath registers.
    logic [fbscr_pkg::STEP_W-1:0]          step_reg, step_next;
    fbscr_pkg::ctrl_word_t                 ctrl;
    logic signed [fbscr_pkg::HIST_W-1:0]   x_reg;
    logic signed [fbscr_pkg::PROD_W-1:0]   prod_reg;
    logic signed [fbscr_pkg::ACC_W-1:0]    acc_reg;
    logic signed [fbscr_pkg::HIST_W-1:0]   s1_hist_reg [4];
    logic signed [fbscr_pkg::HIST_W-1:0]   s2_hist_reg [4];
    logic                                  decision_reg;
    logic [fbscr_pkg::DHIST_W-1:0]         dhist_reg;
    logic                                  edge_seen_reg;
    logic [fbscr_pkg::ERR_W-1:0]           err_reg;
    logic [fbscr_pkg::PHASE_W-1:0]         phase_reg;
    logic                                  emitted_reg;
    logic                                  m_valid_reg;
    logic                                  m_data_bit_reg;

    // Combinational datapath signals.
    logic                                  positive;
    logic                                  slice;
    logic signed [fbscr_pkg::HIST_W-1:0]   h0, h1, h2, h3;
    logic signed [fbscr_pkg::COEF_W-1:0]   c0, c1, c2;
    logic signed [fbscr_pkg::SUM_W-1:0]    tap_sum;
    logic signed [fbscr_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [fbscr_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [fbscr_pkg::ACC_W-1:0]    acc_rnd;
    logic signed [fbscr_pkg::ACC_W-Q_SHIFT_L-1:0] y_wide;
    logic signed [fbscr_pkg::HIST_W-1:0]   y_sat;
    logic                                  new_decision;
    logic [fbscr_pkg::DHIST_W-1:0]         dhist_new;
    logic                                  edge_now;
    logic [fbscr_pkg::PHASE_W:0]           phase_inc;
    logic [fbscr_pkg::PHASE_W:0]           phase_sum;
    logic                                  emit;
    logic                                  wrap;
    logic                                  out_free;
    logic                                  advance;

    // Current control word from the program store.
    assign ctrl = fbscr_pkg::ucode(step_reg);

    assign s_ready    = (ctrl.cond == fbscr_pkg::COND_IN_VALID);
    assign cfg_ready  = 1'b1;
    assign m_valid    = m_valid_reg;
    assign m_data_bit = m_data_bit_reg;

    // Hysteresis slicer with its level at zero: a zero sample keeps the state.
    assign positive = !s_sample[fbscr_pkg::SAMPLE_W-1] && (s_sample != '0);
    assign slice    = decision_reg ? !s_sample[fbscr_pkg::SAMPLE_W-1] : positive;

    // Select the history and coefficients of the active filter stage.
    always_comb begin
        if (ctrl.stage2) begin
            h0 = s2_hist_reg[0];
            h1 = s2_hist_reg[1];
            h2 = s2_hist_reg[2];
            h3 = s2_hist_reg[3];
            c0 = s2_coef_reg[0];
            c1 = s2_coef_reg[1];
            c2 = s2_coef_reg[2];
        end else begin
            h0 = s1_hist_reg[0];
            h1 = s1_hist_reg[1];
            h2 = s1_hist_reg[2];
            h3 = s1_hist_reg[3];
            c0 = s1_coef_reg[0];
            c1 = s1_coef_reg[1];
            c2 = s1_coef_reg[2];
        end
    end

    // Feed-forward taps share one coefficient: x + 2*x[n-1] + x[n-2].
    assign tap_sum = fbscr_pkg::SUM_W'(x_reg) + (fbscr_pkg::SUM_W'(h0) <<< 1)
                   + fbscr_pkg::SUM_W'(h1);

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            fbscr_pkg::MUL_SUM: begin
                mul_a = tap_sum;
                mul_b = fbscr_pkg::MUL_B_W'(c0);
            end
            fbscr_pkg::MUL_FB1: begin
                mul_a = fbscr_pkg::MUL_A_W'(h2);
                mul_b = fbscr_pkg::MUL_B_W'(c1);
            end
            fbscr_pkg::MUL_FB2: begin
                mul_a = fbscr_pkg::MUL_A_W'(h3);
                mul_b = fbscr_pkg::MUL_B_W'(c2);
            end
            fbscr_pkg::MUL_GAIN: begin
                mul_a = $signed({{(fbscr_pkg::MUL_A_W-fbscr_pkg::BASE_W){1'b0}}, base_reg});
                mul_b = $signed({{(fbscr_pkg::MUL_B_W-fbscr_pkg::GAIN_W){1'b0}}, gain_reg});
            end
            fbscr_pkg::MUL_ERR: begin
                mul_a = $signed({{(fbscr_pkg::MUL_A_W-fbscr_pkg::ERR_W){1'b0}}, err_reg});
                mul_b = $signed({1'b0, prod_reg[fbscr_pkg::MUL_B_W-2:0]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Round half up, drop the fraction, and saturate to the history width.
    assign acc_rnd = acc_reg + (fbscr_pkg::ACC_W'(1) <<< (Q_SHIFT_L - 1));
    assign y_wide  = acc_rnd[fbscr_pkg::ACC_W-1:Q_SHIFT_L];

    always_comb begin
        if ((y_wide[fbscr_pkg::ACC_W-Q_SHIFT_L-1:fbscr_pkg::HIST_W-1] == '0) ||
            (y_wide[fbscr_pkg::ACC_W-Q_SHIFT_L-1:fbscr_pkg::HIST_W-1] == '1)) begin
            y_sat = y_wide[fbscr_pkg::HIST_W-1:0];
        end else if (y_wide[fbscr_pkg::ACC_W-Q_SHIFT_L-1]) begin
            y_sat = {1'b1, {(fbscr_pkg::HIST_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(fbscr_pkg::HIST_W-1){1'b1}}};
        end
    end

    // Bit decision and edge detection over the decision window.
    assign new_decision = !y_sat[fbscr_pkg::HIST_W-1] && (y_sat != '0);
    assign dhist_new    = {dhist_reg[fbscr_pkg::DHIST_W-2:0], new_decision};
    assign edge_now     = dhist_new[0] ^ dhist_new[fbscr_pkg::EDGE_SPAN];

    // Phase advance: nominal step plus the scaled loop correction.
    assign phase_inc = {2'b00, base_reg}
                     + {1'b0, prod_reg[fbscr_pkg::LOOP_SHIFT+fbscr_pkg::PHASE_W-1:
                                       fbscr_pkg::LOOP_SHIFT]};
    assign phase_sum = {1'b0, phase_reg} + phase_inc;
    assign emit      = (phase_sum >= fbscr_pkg::HALF_TURN) && !emitted_reg;
    assign wrap      = phase_sum[fbscr_pkg::PHASE_W];
    assign out_free  = !m_valid_reg || m_ready;

    // Step advance with conditional waits and the jump back to the start.
    always_comb begin
        case (ctrl.cond)
            fbscr_pkg::COND_IN_VALID: advance = s_valid;
            fbscr_pkg::COND_OUT_FREE: advance = out_free || !emit;
            default:                  advance = 1'b1;
        endcase
        if (!advance) begin
            step_next = step_reg;
        end else if (ctrl.last) begin
            step_next = '0;
        end else begin
            step_next = step_reg + fbscr_pkg::STEP_W'(1);
        end
    end

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= fbscr_pkg::BASE_RESET;
            gain_reg <= fbscr_pkg::GAIN_RESET;
            for (int i = 0; i < 3; i++) begin
                s1_coef_reg[i] <= '0;
                s2_coef_reg[i] <= '0;
            end
        end else if (cfg_valid) begin
            unique case (cfg_index)
                fbscr_pkg::REG_PHASE_STEP_BASE: base_reg <= cfg_data[fbscr_pkg::BASE_W-1:0];
                fbscr_pkg::REG_LOOP_GAIN:       gain_reg <= cfg_data[fbscr_pkg::GAIN_W-1:0];
                fbscr_pkg::REG_S1_INPUT_COEF:   s1_coef_reg[0] <= $signed(cfg_data);
                fbscr_pkg::REG_S1_FB1_COEF:     s1_coef_reg[1] <= $signed(cfg_data);
                fbscr_pkg::REG_S1_FB2_COEF:     s1_coef_reg[2] <= $signed(cfg_data);
                fbscr_pkg::REG_S2_INPUT_COEF:   s2_coef_reg[0] <= $signed(cfg_data);
                fbscr_pkg::REG_S2_FB1_COEF:     s2_coef_reg[1] <= $signed(cfg_data);
                fbscr_pkg::REG_S2_FB2_COEF:     s2_coef_reg[2] <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
        end else begin
            step_reg <= step_next;
        end
    end

    // Shared multiplier and accumulator.
    always_ff @(posedge aclk) begin
        if (ctrl.mul_sel != fbscr_pkg::MUL_NONE) begin
            prod_reg <= mul_a * mul_b;
        end
        case (ctrl.acc_op)
            fbscr_pkg::ACC_LOAD: acc_reg <= prod_reg[fbscr_pkg::ACC_W-1:0];
            fbscr_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_reg[fbscr_pkg::ACC_W-1:0];
            default: ;
        endcase
    end

    // Filter input, filter histories, decision, edge, phase and result state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                s1_hist_reg[i] <= '0;
                s2_hist_reg[i] <= '0;
            end
            decision_reg   <= 1'b0;
            dhist_reg      <= '0;
            edge_seen_reg  <= 1'b0;
            err_reg        <= '0;
            phase_reg      <= '0;
            emitted_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (ctrl.act)
                fbscr_pkg::ACT_ACCEPT: begin
                    if (s_valid) begin
                        x_reg <= slice ? fbscr_pkg::DRIVE_POS : fbscr_pkg::DRIVE_NEG;
                    end
                end
                fbscr_pkg::ACT_FIN1: begin
                    s1_hist_reg[1] <= s1_hist_reg[0];
                    s1_hist_reg[0] <= x_reg;
                    s1_hist_reg[3] <= s1_hist_reg[2];
                    s1_hist_reg[2] <= y_sat;
                    x_reg          <= y_sat;
                end
                fbscr_pkg::ACT_FIN2: begin
                    s2_hist_reg[1] <= s2_hist_reg[0];
                    s2_hist_reg[0] <= x_reg;
                    s2_hist_reg[3] <= s2_hist_reg[2];
                    s2_hist_reg[2] <= y_sat;
                    decision_reg   <= new_decision;
                    dhist_reg      <= dhist_new;
                    edge_seen_reg  <= edge_now;
                    // Latch the distance to the nearest wrap on a new edge.
                    if (edge_now && !edge_seen_reg) begin
                        if ({1'b0, phase_reg} > fbscr_pkg::HALF_TURN) begin
                            err_reg <= fbscr_pkg::PHASE_W'(fbscr_pkg::FULL_TURN
                                                          - {1'b0, phase_reg});
                        end else begin
                            err_reg <= phase_reg;
                        end
                    end
                end
                fbscr_pkg::ACT_PHASE: begin
                    if (advance) begin
                        phase_reg <= phase_sum[fbscr_pkg::PHASE_W-1:0];
                        if (wrap) begin
                            emitted_reg <= 1'b0;
                        end else if (emit) begin
                            emitted_reg <= 1'b1;
                        end
                        if (emit) begin
                            m_valid_reg    <= 1'b1;
                            m_data_bit_reg <= decision_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // A new result appears only from the phase step.
    a_result_from_phase_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(ctrl.act == fbscr_pkg::ACT_PHASE))
        else $error("result raised outside the phase step");

    // Once the bit of this period is out, the phase is past its midpoint.
    a_emitted_past_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        emitted_reg |-> phase_reg[fbscr_pkg::PHASE_W-1])
        else $error("bit marked emitted before the phase midpoint");

    // An accepted sample starts the filter program.
    a_accept_starts_program: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (step_reg == fbscr_pkg::STEP_W'(1)))
        else $error("sample transfer did not start the program");

    // A blocked result holds the phase step and its state.
    a_blocked_holds_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.act == fbscr_pkg::ACT_PHASE && emit && m_valid_reg && !m_ready)
        |=> ($stable(phase_reg) && $stable(step_reg)))
        else $error("phase step advanced while the result was blocked");

endmodule

### tb/fsk_bit_slicer_clock_recovery_core_tb.sv
// ----------------------------------------------------------------------------
// FSK bit slicer clock recovery core testbench
// Feeds audio samples through the valid/ready input channel and compares
// every recovered bit with an in-bench model of the slicer, the two biquads
// and the phase-locked bit clock. A directed table comes first, followed by
// randomized FSK-like bursts under several register settings.
// ----------------------------------------------------------------------------
module fsk_bit_slicer_clock_recovery_core_tb;
    import fbscr_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned STALL_LIMIT  = 4000;
    localparam int unsigned ITEM_TARGET  = 400;
    localparam int unsigned REPORT_MAX   = 10;

    // Register indexes that are decoded to nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

    // Second order low-pass, cutoff near a tenth of the sample rate, Q3.22.
    localparam logic [COEF_W-1:0] LP_IN  = 26'(282950);
    localparam logic [COEF_W-1:0] LP_FB1 = 26'(4794100);
    localparam logic [COEF_W-1:0] LP_FB2 = 26'(-1731400);
    localparam logic [COEF_W-1:0] COEF_MAX = 26'h1ff_ffff;
    localparam logic [COEF_W-1:0] COEF_MIN = 26'h200_0000;

    typedef enum logic {
        ROW_WRITE,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   smp;
        logic                  typed;
        logic                  has_bit;
        logic                  bit_val;
    } plan_row_t;

    // Directed stimulus. Rows marked typed carry their own expectation: with
    // zero coefficients the decision stays low and the phase is easy to follow.
    localparam int PLAN_LEN = 34;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_WRITE,  REG_PHASE_STEP_BASE, 26'h3ff_ffff, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b1, 1'b1, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h0000, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h0001, 1'b1, 1'b1, 1'b0},
        '{ROW_WRITE,  REG_SPARE_LAST,      26'h3ff_ffff, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_SPARE_FIRST,     26'h000_0000, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'hffff, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h4000, 1'b1, 1'b1, 1'b0},
        '{ROW_WRITE,  REG_PHASE_STEP_BASE, 26'h000_0000, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b1, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b1, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_PHASE_STEP_BASE, 26'h000_0001, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_LOOP_GAIN,       26'h3ff_ffff, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_S1_INPUT_COEF,   26'h040_0000, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_S2_INPUT_COEF,   26'h040_0000, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h0001, 1'b0, 1'b0, 1'b0},
        '{ROW_WRITE,  REG_PHASE_STEP_BASE, 26'h000_7fff, '0, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h0001, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'hffff, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h0000, 1'b0, 1'b0, 1'b0},
        '{ROW_SAMPLE, '0, '0, 16'h7fff, 1'b0, 1'b0, 1'b0}
    };

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [SAMPLE_W-1:0]   s_sample  = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_data_bit;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Expectation attached to the sample currently offered.
    logic row_typed   = 1'b0;
    logic row_has_bit = 1'b0;
    logic row_bit     = 1'b0;

    // Model copy of the registers and state.
    logic [BASE_W-1:0]        step_base;
    logic [GAIN_W-1:0]        corr_gain;
    logic signed [COEF_W-1:0] coef_tab [2][3];
    longint                   stage_hist [2][4];
    logic                     cur_bit;
    logic [DHIST_W-1:0]       bit_hist;
    logic [PHASE_W:0]         acc_phase;
    logic                     edge_flag;
    logic [ERR_W-1:0]         phase_err;
    logic                     emitted;

    logic        bits_due [$];
    int unsigned samples_sent = 0;
    int unsigned bits_checked = 0;
    int unsigned mismatches   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned cur_step     = 0;
    logic        hold_req     = 1'b0;
    logic        hold_done    = 1'b0;
    logic        calm         = 1'b0;

    fsk_bit_slicer_clock_recovery_core u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sample   (s_sample),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data_bit (m_data_bit),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Model state after reset.
    function automatic void clear_model();
        step_base = BASE_RESET;
        corr_gain = GAIN_RESET;
        for (int s = 0; s < 2; s++) begin
            for (int k = 0; k < 3; k++) coef_tab[s][k] = '0;
            for (int k = 0; k < 4; k++) stage_hist[s][k] = 0;
        end
        cur_bit   = 1'b0;
        bit_hist  = '0;
        acc_phase = '0;
        edge_flag = 1'b0;
        phase_err = '0;
        emitted   = 1'b0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        int k;
        case (idx)
            REG_PHASE_STEP_BASE: step_base = data[BASE_W-1:0];
            REG_LOOP_GAIN:       corr_gain = data[GAIN_W-1:0];
            REG_S1_INPUT_COEF, REG_S1_FB1_COEF, REG_S1_FB2_COEF,
            REG_S2_INPUT_COEF, REG_S2_FB1_COEF, REG_S2_FB2_COEF: begin
                k = int'(idx) - int'(REG_S1_INPUT_COEF);
                coef_tab[k / 3][k % 3] = data;
            end
            default: ;
        endcase
    endfunction

    // One biquad stage: exact accumulate, round half up, saturate to 26 bits.
    function automatic longint biquad_step(input int s, input longint x);
        longint acc;
        longint y;
        acc = longint'(coef_tab[s][0]) * (x + 2 * stage_hist[s][0] + stage_hist[s][1])
            + longint'(coef_tab[s][1]) * stage_hist[s][2]
            + longint'(coef_tab[s][2]) * stage_hist[s][3];
        y = (acc + (longint'(1) <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
        if (y > 64'sd33554431)  y = 64'sd33554431;
        if (y < -64'sd33554432) y = -64'sd33554432;
        stage_hist[s][1] = stage_hist[s][0];
        stage_hist[s][0] = x;
        stage_hist[s][3] = stage_hist[s][2];
        stage_hist[s][2] = y;
        return y;
    endfunction

    // Slice one sample, update the bit clock, and report the bit due, if any.
    function automatic void recover_bit(input logic [SAMPLE_W-1:0] smp,
                                        output logic got, output logic val);
        logic             slice;
        logic             edge_now;
        longint           x;
        longint           y;
        longint unsigned  corr;
        logic [PHASE_W:0] inc;
        slice = cur_bit;
        if (!slice) begin
            if (!smp[SAMPLE_W-1] && smp != '0) slice = 1'b1;
        end else if (smp[SAMPLE_W-1]) begin
            slice = 1'b0;
        end
        x = slice ? longint'(DRIVE_POS) : longint'(DRIVE_NEG);
        y = biquad_step(1, biquad_step(0, x));
        cur_bit  = (y > 0);
        bit_hist = {bit_hist[DHIST_W-2:0], cur_bit};
        edge_now = bit_hist[0] ^ bit_hist[EDGE_SPAN];

        // A fresh edge latches the distance to the nearest wrap.
        if (edge_now && !edge_flag)
            phase_err = (acc_phase > HALF_TURN) ? 16'(FULL_TURN - acc_phase)
                                                : acc_phase[PHASE_W-1:0];
        corr = (64'(step_base) * 64'(corr_gain) * 64'(phase_err)) >> LOOP_SHIFT;
        inc  = 17'(64'(step_base) + corr);
        acc_phase = 17'(acc_phase + inc);
        edge_flag = edge_now;

        got = 1'b0;
        val = 1'b0;
        if (acc_phase >= HALF_TURN && !emitted) begin
            got = 1'b1;
            val = cur_bit;
            emitted = 1'b1;
        end
        if (acc_phase >= FULL_TURN) begin
            acc_phase[PHASE_W] = 1'b0;
            emitted = 1'b0;
        end
    endfunction

    // Observe all three channels at the clock edge and check the bits.
    always @(posedge aclk) begin
        logic got;
        logic val;
        logic want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
            if (m_valid && m_ready) begin
                bits_checked++;
                if (bits_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("data_bit %0b delivered with no bit due", m_data_bit);
                end else begin
                    want = bits_due.pop_front();
                    if (m_data_bit !== want) begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                            $display("data_bit mismatch on bit %0d: expected %0b, got %0b",
                                     bits_checked, want, m_data_bit);
                    end
                end
            end
            if (s_valid && s_ready) begin
                recover_bit(s_sample, got, val);
                if (row_typed) begin
                    got = row_has_bit;
                    val = row_bit;
                end
                if (got) bits_due.push_back(val);
            end
            if ((cfg_valid && cfg_ready) || (m_valid && m_ready) || (s_valid && s_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Result side: random stalls, one long hold-off on request, none when calm.
    initial begin
        forever begin
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic typed,
                               input logic has_bit, input logic bit_val);
        int unsigned gap;
        s_valid     <= 1'b1;
        s_sample    <= v;
        row_typed   <= typed;
        row_has_bit <= has_bit;
        row_bit     <= bit_val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Leaves cfg_valid high so that back-to-back writes stay continuous.
    task automatic put_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Wait until every due bit has arrived and the last sample has finished.
    task automatic settle();
        s_valid <= 1'b0;
        while (bits_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Program every register; unused upper data bits get random filler.
    task automatic load_setting(input logic [BASE_W-1:0] base, input logic [GAIN_W-1:0] gain,
                                input logic [COEF_W-1:0] a0, input logic [COEF_W-1:0] a1,
                                input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] b0,
                                input logic [COEF_W-1:0] b1, input logic [COEF_W-1:0] b2);
        settle();
        put_register(REG_PHASE_STEP_BASE, 26'({$urandom, base}));
        put_register(REG_LOOP_GAIN,       26'({$urandom, gain}));
        put_register(REG_S1_INPUT_COEF,   a0);
        put_register(REG_S1_FB1_COEF,     a1);
        put_register(REG_S1_FB2_COEF,     a2);
        put_register(REG_S2_INPUT_COEF,   b0);
        put_register(REG_S2_FB1_COEF,     b1);
        put_register(REG_S2_FB2_COEF,     b2);
        cfg_valid <= 1'b0;
        cur_step = base;
    endtask

    // FSK-like signal: runs of one polarity about a bit long, with glitches,
    // zero samples and full-range noise mixed in.
    task automatic send_signal(input int unsigned count);
        int unsigned         left;
        int unsigned         run;
        int unsigned         spb;
        logic                level;
        logic [SAMPLE_W-1:0] mag;
        logic [SAMPLE_W-1:0] v;
        left = count;
        spb = (cur_step == 0) ? 16 : 65536 / cur_step;
        if (spb > 40) spb = 40;
        if (spb == 0) spb = 1;
        while (left != 0) begin
            level = 1'($urandom);
            if ($urandom_range(0, 7) == 0)
                run = $urandom_range(1, 3);
            else
                run = spb - 1 + $urandom_range(0, 2);
            if (run == 0) run = 1;
            while (run != 0 && left != 0) begin
                mag = 16'($urandom_range(1, 32767));
                case ($urandom_range(0, 15))
                    0:       v = 16'($urandom);
                    1:       v = '0;
                    default: v = level ? mag : -mag;
                endcase
                send_sample(v, 1'b0, 1'b0, 1'b0);
                run--;
                left--;
            end
        end
    endtask

    initial begin
        clear_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table.
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].kind == ROW_WRITE) begin
                if (i == 0 || PLAN[i-1].kind != ROW_WRITE) settle();
                put_register(PLAN[i].idx, PLAN[i].data);
                if (i == PLAN_LEN - 1 || PLAN[i+1].kind != ROW_WRITE) cfg_valid <= 1'b0;
            end else begin
                send_sample(PLAN[i].smp, PLAN[i].typed, PLAN[i].has_bit, PLAN[i].bit_val);
            end
        end

        // Random phases under different loop and filter settings.
        load_setting(15'd8192, 16'd164, LP_IN, LP_FB1, LP_FB2, LP_IN, LP_FB1, LP_FB2);
        send_signal(60);
        load_setting(15'd8192, 16'hffff, LP_IN, LP_FB1, LP_FB2, LP_IN, LP_FB1, LP_FB2);
        send_signal(60);
        load_setting(15'd4096, 16'd0, LP_IN, LP_FB1, LP_FB2, LP_IN, LP_FB1, LP_FB2);
        send_signal(50);

        // Fast bit clock with saturating filters; the result side holds off
        // long enough for the core to back up into its input.
        load_setting(15'h7fff, 16'd30000, COEF_MAX, COEF_MIN, COEF_MAX,
                     COEF_MIN, COEF_MAX, COEF_MIN);
        hold_req = 1'b1;
        send_signal(60);

        load_setting(15'd1, 16'hffff, COEF_MIN, COEF_MIN, COEF_MIN,
                     COEF_MIN, COEF_MIN, COEF_MIN);
        send_signal(20);
        load_setting(15'd16384, 16'($urandom), 26'($urandom), 26'($urandom), 26'($urandom),
                     26'($urandom), 26'($urandom), 26'($urandom));
        send_signal(60);

        // Closing stretch without any idling on either side.
        load_setting(15'd8192, 16'd2000, LP_IN, LP_FB1, LP_FB2, LP_IN, LP_FB1, LP_FB2);
        calm = 1'b1;
        while (samples_sent < ITEM_TARGET)
            send_signal(8);
        settle();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### files.f
hw/rtl/fbscr_pkg.sv
hw/rtl/fsk_bit_slicer_clock_recovery_core.sv
tb/fsk_bit_slicer_clock_recovery_core_tb.sv
